### src/dq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// No dependencies.
package dq_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5,
    KIND_CLEAR      = 3'd6
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NULL  = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_e;

  // Per-cycle operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN_FRONT,   // every cell takes its front neighbor
    CELL_SHIFT_OUT_FRONT,  // every cell takes its back neighbor
    CELL_FILL_BACK,        // first empty cell takes the new value
    CELL_DROP_BACK,        // last occupied cell goes empty
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

### src/dq_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready plus kind and push value.
// Depends on dq_pkg.
interface dq_req_if;
  import dq_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] item_value;

  modport source (output valid, kind, item_value, input ready);
  modport sink   (input valid, kind, item_value, output ready);
endinterface

### src/dq_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready plus value, status and count.
// Depends on dq_pkg.
interface dq_rsp_if;
  import dq_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  out_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, out_value, status, count, input ready);
  modport sink   (input valid, out_value, status, count, output ready);
endinterface

### src/dq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the deque row: a value and an occupied flag.
// Depends on dq_pkg.
module dq_cell
  import dq_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [VALUE_BITS-1:0] fill_value_i,
  input  logic [VALUE_BITS-1:0] front_data_i,
  input  logic                  front_valid_i,
  input  logic [VALUE_BITS-1:0] back_data_i,
  input  logic                  back_valid_i,
  output logic [VALUE_BITS-1:0] data_o,
  output logic                  valid_o,
  output logic                  last_o
);

  logic [VALUE_BITS-1:0] data_q, data_d;
  logic                  valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      CELL_SHIFT_IN_FRONT: begin
        data_d  = front_data_i;
        valid_d = front_valid_i;
      end
      CELL_SHIFT_OUT_FRONT: begin
        data_d  = back_data_i;
        valid_d = back_valid_i;
      end
      CELL_FILL_BACK: begin
        if (!valid_q && front_valid_i) begin
          data_d  = fill_value_i;
          valid_d = 1'b1;
        end
      end
      CELL_DROP_BACK: begin
        if (last_o) valid_d = 1'b0;
      end
      CELL_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign last_o  = valid_q && !back_valid_i;

endmodule

### src/double_ended_queue_top.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of nonzero values, built as a row of DEPTH cells.
// Depends on dq_pkg, dq_req_if, dq_rsp_if and dq_cell.
//
// Entries sit in a row of cells with the front always in cell 0 and the
// occupied cells contiguous from there. A push at the front shifts the whole
// row back by one cell; a pop at the front shifts it forward. A push at the
// back fills the first empty cell, and a pop at the back empties the last
// occupied one. The back value is taken through a one-hot select over the
// row, keyed by each cell's own "last occupied" flag. One request is taken
// per clock while the output register can take it; the row, the count and
// that register all update at the transfer edge. A new request is
// accepted whenever that register is empty or being drained in the same
// cycle, so a stalled result blocks further requests but costs no bubble
// otherwise. Pushing zero gives the null status; pushing into a full row
// gives the full status; popping or peeking an empty row gives zero with the
// empty status. Clear empties every cell at once. No clearing pass after
// reset: the occupied flags reset and stale cell data is never read.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Cell row wiring; index DEPTH is the empty slot past the back.
  logic [VALUE_BITS-1:0] cell_data  [DEPTH+1];
  logic                  cell_valid [DEPTH+1];
  logic                  cell_last  [DEPTH];
  cell_ctrl_t            ctrl;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [VALUE_W-1:0]    out_value_q;
  logic [STATUS_W-1:0]   status_q;
  logic [COUNT_W-1:0]    out_count_q;

  logic                  accept;
  logic [VALUE_BITS-1:0] push_value;
  logic [VALUE_BITS-1:0] back_value;
  logic [VALUE_BITS-1:0] result;
  status_e               status;
  logic                  is_full;
  logic                  is_empty;

  // Input value taken to VALUE_BITS bits, result taken back to the port width.
  logic [63:0]           in_wide;
  logic [63:0]           out_wide;

  assign in_wide    = 64'(req_i.item_value);
  assign push_value = in_wide[VALUE_BITS-1:0];

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !out_valid_q || rsp_o.ready;

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  // Row edges: the slot past the back is empty; the push value enters cell 0.
  assign cell_data[DEPTH]  = '0;
  assign cell_valid[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] front_data;
    logic                  front_valid;

    if (i == 0) begin : g_head
      assign front_data  = push_value;
      assign front_valid = 1'b1;
    end else begin : g_body
      assign front_data  = cell_data[i-1];
      assign front_valid = cell_valid[i-1];
    end

    dq_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .fill_value_i  (push_value),
      .front_data_i  (front_data),
      .front_valid_i (front_valid),
      .back_data_i   (cell_data[i+1]),
      .back_valid_i  (cell_valid[i+1]),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .last_o        (cell_last[i])
    );
  end

  // One-hot select of the back entry.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_data[i] & {VALUE_BITS{cell_last[i]}});
    end
  end

  // Request decode.
  always_comb begin
    ctrl.op = CELL_HOLD;
    count_d = count_q;
    result  = '0;
    status  = STATUS_OK;
    case (kind_e'(req_i.kind))
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (push_value == '0) begin
          status = STATUS_NULL;
        end else if (is_full) begin
          status = STATUS_FULL;
        end else begin
          ctrl.op = (kind_e'(req_i.kind) == KIND_PUSH_FRONT) ?
                    CELL_SHIFT_IN_FRONT : CELL_FILL_BACK;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_POP_FRONT, KIND_PEEK_FRONT: begin
        if (is_empty) begin
          status = STATUS_EMPTY;
        end else begin
          result = cell_data[0];
          if (kind_e'(req_i.kind) == KIND_POP_FRONT) begin
            ctrl.op = CELL_SHIFT_OUT_FRONT;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      KIND_POP_BACK, KIND_PEEK_BACK: begin
        if (is_empty) begin
          status = STATUS_EMPTY;
        end else begin
          result = back_value;
          if (kind_e'(req_i.kind) == KIND_POP_BACK) begin
            ctrl.op = CELL_DROP_BACK;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      KIND_CLEAR: begin
        ctrl.op = CELL_CLEAR;
        count_d = '0;
      end
      default: ;
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
      count_d = count_q;
    end
  end

  assign out_wide = 64'(result);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_wide[VALUE_W-1:0];
      status_q    <= status;
      out_count_q <= COUNT_W'(count_d);
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_value = out_value_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.count     = out_count_q;

endmodule
